/* rtl/core/sonar_pot_pid_fan_control_defines.svh */
// Assertion macros for the fan PID controller.
// Uses clk_i and rst_ni of the including module; no other dependencies.
`ifndef SONAR_POT_PID_FAN_CONTROL_DEFINES_SVH
`define SONAR_POT_PID_FAN_CONTROL_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SPFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SPFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/spfc_pkg.sv */
// Types, constants and the microcode ROM of the fan PID controller.
// No dependencies; used by sonar_pot_pid_fan_control.
package spfc_pkg;

  // register indexes of the configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV = 2'd2;

  localparam logic [15:0] GAIN_PROP_RST  = 16'hF700;  // -9.0 in Q8.8
  localparam logic [15:0] GAIN_INTEG_RST = 16'h0000;
  localparam logic [15:0] GAIN_DERIV_RST = 16'hF600;  // -10.0 in Q8.8

  // fixed widths
  localparam int unsigned A_W    = 33;  // multiplier operand A, signed
  localparam int unsigned B_W    = 29;  // multiplier operand B, signed
  localparam int unsigned P_W    = A_W + B_W;
  localparam int unsigned ACC_W  = 50;
  localparam int unsigned DRV_W  = 10;

  // target: (110081 - 25*r) / 3, reciprocal exact for 17-bit dividends
  localparam logic [16:0]    TGT_BASE  = 17'd110081;
  localparam logic [B_W-1:0] RECIP3    = 29'd87382;    // ceil(2^18/3)
  localparam int unsigned    SH3       = 18;
  // sonar: floor((h*10976 + 625) / 1250)
  localparam logic [B_W-1:0] SONAR_K   = 29'd10976;
  localparam logic [27:0]    SONAR_RND = 28'd625;
  localparam logic [B_W-1:0] RECIP1250 = 29'd219902326; // ceil(2^38/1250)
  localparam int unsigned    SH1250    = 38;
  localparam logic [16:0]    MEAS_MAX  = 17'h1FFFF;
  // integral step: (|e|*512 + 50) / 100
  localparam logic [27:0]    INT_RND   = 28'd50;
  localparam logic [B_W-1:0] RECIP100  = 29'd85899346;  // ceil(2^33/100)
  localparam int unsigned    SH100     = 33;
  localparam logic [B_W-1:0] DERIV_K   = 29'd50;        // 1 / 20 ms

  // operand selects
  typedef enum logic [2:0] {
    A_N, A_HALF, A_TMP, A_ERR, A_INTEG, A_DIFF, A_DER
  } asel_e;

  typedef enum logic [2:0] {
    B_R3, B_SONAR, B_R1250, B_R100, B_FIFTY, B_KP, B_KI, B_KD
  } bsel_e;

  // writeback of the registered product or of derived values
  typedef enum logic [3:0] {
    WB_NONE, WB_TGT, WB_TMP, WB_MEAS, WB_ERR, WB_MAG, WB_INTEG, WB_DER,
    WB_ACC_LD, WB_ACC_ADD, WB_ACC_ADD8, WB_FIN
  } wb_e;

  typedef enum logic {
    JMP_NEXT,       // advance the step counter
    JMP_WAIT_DONE   // stay until the output slot is free, then end
  } jmp_e;

  typedef struct packed {
    asel_e a_sel;
    bsel_e b_sel;
    logic  mul_en;
    wb_e   wb;
    jmp_e  jmp;
  } uword_t;

  localparam int unsigned STEP_W   = 4;
  localparam int unsigned PROG_LEN = 14;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROG_LEN - 1);

  // Microcode: a multiply issued in step k is written back in step k+1.
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{a_sel: A_N, b_sel: B_R3, mul_en: 1'b0, wb: WB_NONE, jmp: JMP_NEXT};
    unique case (step)
      4'd0:  w = '{A_N,     B_R3,    1'b1, WB_NONE,     JMP_NEXT};
      4'd1:  w = '{A_HALF,  B_SONAR, 1'b1, WB_TGT,      JMP_NEXT};
      4'd2:  w = '{A_N,     B_R3,    1'b0, WB_TMP,      JMP_NEXT};
      4'd3:  w = '{A_TMP,   B_R1250, 1'b1, WB_NONE,     JMP_NEXT};
      4'd4:  w = '{A_N,     B_R3,    1'b0, WB_MEAS,     JMP_NEXT};
      4'd5:  w = '{A_N,     B_R3,    1'b0, WB_ERR,      JMP_NEXT};
      4'd6:  w = '{A_N,     B_R3,    1'b0, WB_MAG,      JMP_NEXT};
      4'd7:  w = '{A_TMP,   B_R100,  1'b1, WB_NONE,     JMP_NEXT};
      4'd8:  w = '{A_DIFF,  B_FIFTY, 1'b1, WB_INTEG,    JMP_NEXT};
      4'd9:  w = '{A_ERR,   B_KP,    1'b1, WB_DER,      JMP_NEXT};
      4'd10: w = '{A_INTEG, B_KI,    1'b1, WB_ACC_LD,   JMP_NEXT};
      4'd11: w = '{A_DER,   B_KD,    1'b1, WB_ACC_ADD,  JMP_NEXT};
      4'd12: w = '{A_N,     B_R3,    1'b0, WB_ACC_ADD8, JMP_NEXT};
      4'd13: w = '{A_N,     B_R3,    1'b0, WB_FIN,      JMP_WAIT_DONE};
      default: w = '{A_N,   B_R3,    1'b0, WB_FIN,      JMP_WAIT_DONE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/sonar_pot_pid_fan_control.sv */
// Fan PID controller: microcoded sequencer around one shared multiplier.
// Depends on spfc_pkg and sonar_pot_pid_fan_control_defines.svh.
//
// Usage
// - Input channel (in_valid_i / in_stall_o): one beat per control tick,
//   carrying the byte-swapped converter word and the sonar echo width.
// - Output channel (out_valid_o / out_stall_i): one beat per input beat
//   with drive level, signed total, target, measured distance and error.
// - Config channel (cfg_valid_i / cfg_ready_o): writes the three Q8.8 gains
//   by index; unknown indexes are dropped. Write only while idle.
// - Operands are captured on the accepting edge, then a 14-step microprogram
//   runs; its last step loads the result into the output register.
// - A new beat is taken only after the program for the last one is through:
//   the 14 steps run, then the sequencer goes idle to take the next beat. The
//   cause is the single shared multiplier, which the program uses for eight
//   products in turn.
// - The input channel stalls while a tick is in flight. A finished result
//   sits in the output register, so a new tick can start while it waits.
//   If the receiver still stalls when the next tick ends, the last step
//   holds until the output register frees up.
// - Reset: gains return to -9.0 / 0 / -10.0, the integral and the previous
//   error clear, the sequencer goes idle and no output beat is pending.
`include "sonar_pot_pid_fan_control_defines.svh"

module sonar_pot_pid_fan_control #(
  parameter int unsigned ECHO_LIMIT_US = 18500,
  parameter int unsigned PWM_LEVELS    = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input ticks
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [15:0]                           adc_word_i,
  input  logic [14:0]                           echo_us_i,
  // results
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [spfc_pkg::DRV_W-1:0]            drive_level_o,
  output logic signed [15:0]                    total_signed_o,
  output logic [15:0]                           target_q8_o,
  output logic [16:0]                           measured_q8_o,
  output logic signed [17:0]                    error_q8_o,
  // gain writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [spfc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [15:0]                           cfg_data_i
);

  localparam logic [15:0] ECHO_LIM  = 16'(ECHO_LIMIT_US);
  localparam logic [15:0] DRIVE_MAX = 16'(PWM_LEVELS - 1);
  localparam int unsigned ACC_W_TOP = spfc_pkg::ACC_W - 1;

  // ---------------------------------------------------------------------
  // Sequencer control
  // ---------------------------------------------------------------------
  logic                          busy_q;
  logic [spfc_pkg::STEP_W-1:0]   step_q;
  spfc_pkg::uword_t              uw;
  logic                          in_accept;
  logic                          out_free;
  logic                          fin_go;
  logic                          out_valid_q;

  assign uw          = spfc_pkg::ucode(step_q);
  assign in_stall_o  = busy_q;
  assign in_accept   = in_valid_i && !busy_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign fin_go      = busy_q && (uw.jmp == spfc_pkg::JMP_WAIT_DONE) && out_free;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (in_accept) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      unique case (uw.jmp)
        spfc_pkg::JMP_NEXT:      step_q <= step_q + 1'b1;
        spfc_pkg::JMP_WAIT_DONE: if (out_free) busy_q <= 1'b0;
        default:                 busy_q <= busy_q;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Gains
  // ---------------------------------------------------------------------
  logic [15:0] kp_q, ki_q, kd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= spfc_pkg::GAIN_PROP_RST;
      ki_q <= spfc_pkg::GAIN_INTEG_RST;
      kd_q <= spfc_pkg::GAIN_DERIV_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        spfc_pkg::CFG_GAIN_PROP:  kp_q <= cfg_data_i;
        spfc_pkg::CFG_GAIN_INTEG: ki_q <= cfg_data_i;
        spfc_pkg::CFG_GAIN_DERIV: kd_q <= cfg_data_i;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input capture: pot code -> dividend for the target, echo -> half width
  // ---------------------------------------------------------------------
  logic [15:0] swapped;
  logic [11:0] pot_r;
  logic [15:0] echo_lim;
  logic [16:0] n_d;
  logic [13:0] half_d;
  logic [16:0] n_q;
  logic [13:0] half_q;

  assign swapped  = {adc_word_i[7:0], adc_word_i[15:8]};
  assign pot_r    = {~swapped[15], swapped[14:4]};  // +2048 mod 4096
  assign n_d      = spfc_pkg::TGT_BASE - (17'(pot_r) * 17'd25);
  assign echo_lim = ({1'b0, echo_us_i} > ECHO_LIM) ? ECHO_LIM : {1'b0, echo_us_i};
  assign half_d   = echo_lim[14:1];  // echo is 15 bits, so bit 15 is clear

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      n_q    <= n_d;
      half_q <= half_d;
    end
  end

  // ---------------------------------------------------------------------
  // Shared multiplier, product registered
  // ---------------------------------------------------------------------
  logic signed [spfc_pkg::A_W-1:0] a_op;
  logic signed [spfc_pkg::B_W-1:0] b_op;
  logic signed [spfc_pkg::P_W-1:0] prod_q;

  logic [27:0]        t_q, t_d;
  logic [15:0]        tgt_q, tgt_d;
  logic [16:0]        meas_q, meas_d;
  logic signed [17:0] err_q, err_d;
  logic signed [18:0] diff_q, diff_d;
  logic               neg_q, neg_d;
  logic signed [31:0] integ_q, integ_d;
  logic signed [17:0] last_err_q, last_err_d;
  logic signed [23:0] der_q, der_d;
  logic signed [spfc_pkg::ACC_W-1:0] acc_q, acc_d;

  always_comb begin
    unique case (uw.a_sel)
      spfc_pkg::A_N:     a_op = {16'b0, n_q};
      spfc_pkg::A_HALF:  a_op = {19'b0, half_q};
      spfc_pkg::A_TMP:   a_op = {5'b0, t_q};
      spfc_pkg::A_ERR:   a_op = {{15{err_q[17]}}, err_q};
      spfc_pkg::A_INTEG: a_op = {integ_q[31], integ_q};
      spfc_pkg::A_DIFF:  a_op = {{14{diff_q[18]}}, diff_q};
      spfc_pkg::A_DER:   a_op = {{9{der_q[23]}}, der_q};
      default:           a_op = '0;
    endcase
    unique case (uw.b_sel)
      spfc_pkg::B_R3:    b_op = spfc_pkg::RECIP3;
      spfc_pkg::B_SONAR: b_op = spfc_pkg::SONAR_K;
      spfc_pkg::B_R1250: b_op = spfc_pkg::RECIP1250;
      spfc_pkg::B_R100:  b_op = spfc_pkg::RECIP100;
      spfc_pkg::B_FIFTY: b_op = spfc_pkg::DERIV_K;
      spfc_pkg::B_KP:    b_op = {{13{kp_q[15]}}, kp_q};
      spfc_pkg::B_KI:    b_op = {{13{ki_q[15]}}, ki_q};
      spfc_pkg::B_KD:    b_op = {{13{kd_q[15]}}, kd_q};
      default:           b_op = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && uw.mul_en) begin
      prod_q <= a_op * b_op;
    end
  end

  // ---------------------------------------------------------------------
  // Writeback datapath
  // ---------------------------------------------------------------------
  logic [19:0]        inc_mag;
  logic signed [32:0] inc_s;
  logic signed [32:0] integ_sum;
  logic [16:0]        err_abs;
  logic signed [25:0] quo;
  logic signed [25:0] quo_t;
  logic signed [15:0] total_d;
  logic [15:0]        drive_full;

  assign inc_mag   = prod_q[spfc_pkg::SH100 +: 20];
  assign inc_s     = neg_q ? (33'sd0 - $signed({13'b0, inc_mag}))
                           : $signed({13'b0, inc_mag});
  assign integ_sum = $signed({integ_q[31], integ_q}) + inc_s;
  assign err_abs   = err_q[17] ? 17'(-err_q) : err_q[16:0];

  // sum / 2^24 truncated toward zero, then saturated to 16 bits
  assign quo   = acc_q[ACC_W_TOP:24];
  assign quo_t = quo + 26'(acc_q[spfc_pkg::ACC_W-1] && (acc_q[23:0] != '0));
  always_comb begin
    if (quo_t[25:15] != {11{quo_t[25]}}) begin
      total_d = quo_t[25] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      total_d = quo_t[15:0];
    end
    if (total_d[15]) begin
      drive_full = '0;
    end else if (total_d >= $signed(DRIVE_MAX)) begin
      drive_full = DRIVE_MAX;
    end else begin
      drive_full = total_d;
    end
  end

  always_comb begin
    t_d        = t_q;
    tgt_d      = tgt_q;
    meas_d     = meas_q;
    err_d      = err_q;
    diff_d     = diff_q;
    neg_d      = neg_q;
    integ_d    = integ_q;
    last_err_d = last_err_q;
    der_d      = der_q;
    acc_d      = acc_q;
    if (busy_q) begin
      unique case (uw.wb)
        spfc_pkg::WB_NONE: ;
        spfc_pkg::WB_TGT:  tgt_d = prod_q[spfc_pkg::SH3 +: 16];
        spfc_pkg::WB_TMP:  t_d = prod_q[27:0] + spfc_pkg::SONAR_RND;
        spfc_pkg::WB_MEAS: begin
          // long echoes with a large limit can pass 17 bits
          meas_d = (prod_q[spfc_pkg::P_W-1:spfc_pkg::SH1250+17] != '0)
                   ? spfc_pkg::MEAS_MAX : prod_q[spfc_pkg::SH1250 +: 17];
        end
        spfc_pkg::WB_ERR: begin
          err_d  = $signed({1'b0, meas_q}) - $signed({2'b0, tgt_q});
          diff_d = $signed({err_d[17], err_d}) - $signed({last_err_q[17], last_err_q});
        end
        spfc_pkg::WB_MAG: begin
          t_d   = {2'b0, err_abs, 9'b0} + spfc_pkg::INT_RND;
          neg_d = err_q[17];
        end
        spfc_pkg::WB_INTEG: begin
          if (integ_sum[32] != integ_sum[31]) begin
            integ_d = integ_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          end else begin
            integ_d = integ_sum[31:0];
          end
          last_err_d = err_q;
        end
        spfc_pkg::WB_DER:      der_d = prod_q[23:0];
        spfc_pkg::WB_ACC_LD:   acc_d = {prod_q[41:0], 8'b0};
        spfc_pkg::WB_ACC_ADD:  acc_d = acc_q + prod_q[ACC_W_TOP:0];
        spfc_pkg::WB_ACC_ADD8: acc_d = acc_q + {prod_q[41:0], 8'b0};
        spfc_pkg::WB_FIN: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    tgt_q  <= tgt_d;
    meas_q <= meas_d;
    err_q  <= err_d;
    diff_q <= diff_d;
    neg_q  <= neg_d;
    der_q  <= der_d;
    acc_q  <= acc_d;
  end

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      last_err_q <= '0;
    end else begin
      integ_q    <= integ_d;
      last_err_q <= last_err_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic [spfc_pkg::DRV_W-1:0] drive_q;
  logic signed [15:0]         total_q;
  logic [15:0]                tgt_out_q;
  logic [16:0]                meas_out_q;
  logic signed [17:0]         err_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      drive_q    <= drive_full[spfc_pkg::DRV_W-1:0];
      total_q    <= total_d;
      tgt_out_q  <= tgt_q;
      meas_out_q <= meas_q;
      err_out_q  <= err_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign drive_level_o  = drive_q;
  assign total_signed_o = total_q;
  assign target_q8_o    = tgt_out_q;
  assign measured_q8_o  = meas_out_q;
  assign error_q8_o     = err_out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  logic [17:0] err_chk;
  logic        err_chk_ok;

  assign err_chk    = {1'b0, meas_out_q} - {2'b0, tgt_out_q};
  assign err_chk_ok = (err_chk == err_out_q);

  `SPFC_ASSERT_NXT(a_accept_starts, in_accept, busy_q && (step_q == '0),
                   "accepted tick did not start the program")
  `SPFC_ASSERT_IMP(a_step_in_prog, busy_q, step_q <= spfc_pkg::LAST_STEP,
                   "step counter ran past the program")
  `SPFC_ASSERT_NXT(a_fin_loads, fin_go, out_valid_q && !busy_q,
                   "finished tick did not load the output register")
  `SPFC_ASSERT_IMP(a_err_match, out_valid_q, err_chk_ok,
                   "error field disagrees with measured minus target")
  `SPFC_ASSERT_IMP(a_drive_neg, out_valid_q && total_q[15], drive_q == '0,
                   "negative total must give zero drive")

endmodule
